// ----- sv/gblur_pkg.sv -----
// shared types, constants and kernel weights for the 5x5 gaussian blur
package gblur_pkg;

  // frame geometry and line storage
  localparam int MAX_WIDTH  = 2048;
  localparam int LINES_KEPT = 5;
  localparam int KSIZE      = 5;
  localparam int HALF       = KSIZE / 2;
  localparam int CH         = 3;
  localparam int PIX_BITS   = 8;

  // derived widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int SLOT_W = $clog2(LINES_KEPT);
  localparam int IDX_W  = $clog2(KSIZE);
  localparam int DXY_W  = $clog2(HALF + 1);

  // field and register widths
  localparam int FW_W      = 12;
  localparam int FH_W      = 16;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // arithmetic widths: one kernel row peaks at 255*107, the full sum at 255*273
  localparam int ROW_SUM_W = 15;
  localparam int SUM_W     = 17;

  // divide by 273 as multiply by ceil(2^25/273), exact for sums up to 69615
  localparam int DIV_MUL_W = 17;
  localparam int DIV_MUL   = 122911;
  localparam int DIV_SHIFT = 25;
  localparam int PROD_W    = SUM_W + DIV_MUL_W;

  // kernel weights, sum 273
  localparam int KERN_WT [KSIZE][KSIZE] = '{
    '{1,  4,  7,  4, 1},
    '{4, 16, 26, 16, 4},
    '{7, 26, 41, 26, 7},
    '{4, 16, 26, 16, 4},
    '{1,  4,  7,  4, 1}
  };

  // pixel: channel 0 blue, 1 green, 2 red
  typedef logic [PIX_BITS-1:0] chan_t;
  typedef chan_t [CH-1:0] pix_t;
  typedef pix_t [KSIZE-1:0] pcol_t;
  typedef pcol_t [KSIZE-1:0] win_t;

  // coordinates and end-of-run mark that travel with one result
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } tag_t;

  // channel payloads
  typedef struct packed {
    logic [PIX_BITS-1:0] blue_in;
    logic [PIX_BITS-1:0] green_in;
    logic [PIX_BITS-1:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]  blue_out;
    logic [PIX_BITS-1:0]  green_out;
    logic [PIX_BITS-1:0]  red_out;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 run_last;
  } out_item_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

endpackage

// ----- sv/gblur_lines.sv -----
// line store: one bank per kept row, one write and one registered read per cycle while en is high
module gblur_lines (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [gblur_pkg::SLOT_W-1:0]              wr_slot,
  input  logic [gblur_pkg::COL_W-1:0]               addr,
  input  gblur_pkg::pix_t                           wr_data,
  output gblur_pkg::pix_t [gblur_pkg::LINES_KEPT-1:0] rd_data
);

  // each bank holds one image row, selected by row modulo the bank count
  for (genvar b = 0; b < gblur_pkg::LINES_KEPT; b++) begin : g_bank
    gblur_pkg::pix_t bank_mem [gblur_pkg::MAX_WIDTH];
    gblur_pkg::pix_t rd_data_r;

    always_ff @(posedge clk) begin
      if (en && (int'(wr_slot) == b)) begin
        bank_mem[addr] <= wr_data;
      end
      if (en) begin
        rd_data_r <= bank_mem[addr];
      end
    end

    assign rd_data[b] = rd_data_r;
  end

endmodule

// ----- sv/gblur_conv.sv -----
// weighted 5x5 sum per channel and divide by 273, four register stages
module gblur_conv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 win_valid,
  input  gblur_pkg::win_t      win,
  input  gblur_pkg::tag_t      win_tag,
  output logic                 out_valid,
  output gblur_pkg::out_item_t out_data
);

  localparam int Ks    = gblur_pkg::KSIZE;
  localparam int Ch    = gblur_pkg::CH;
  localparam int RsW   = gblur_pkg::ROW_SUM_W;
  localparam int SumW  = gblur_pkg::SUM_W;
  localparam int ProdW = gblur_pkg::PROD_W;
  localparam int PixB  = gblur_pkg::PIX_BITS;
  localparam int Shift = gblur_pkg::DIV_SHIFT;

  // stage registers
  logic            a_valid_r, b_valid_r, c_valid_r, o_valid_r;
  gblur_pkg::win_t a_win_r;
  gblur_pkg::tag_t a_tag_r, b_tag_r, c_tag_r;
  logic [RsW-1:0]  b_rsum_r [Ch][Ks];
  logic [RsW-1:0]  rsum_nxt [Ch][Ks];
  logic [SumW-1:0] c_sum_r  [Ch];
  logic [SumW-1:0] sum_nxt  [Ch];
  logic [ProdW-1:0] prod    [Ch];
  gblur_pkg::out_item_t o_data_r;
  gblur_pkg::out_item_t o_data_nxt;

  // valid bits move together whenever the output side can advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= win_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      o_valid_r <= c_valid_r;
    end
  end

  // weighted sum along each kernel row
  always_comb begin
    for (int c = 0; c < Ch; c++) begin
      for (int kr = 0; kr < Ks; kr++) begin
        rsum_nxt[c][kr] = '0;
        for (int kc = 0; kc < Ks; kc++) begin
          rsum_nxt[c][kr] = rsum_nxt[c][kr] +
            RsW'(a_win_r[kr][kc][c]) * RsW'(gblur_pkg::KERN_WT[kr][kc]);
        end
      end
    end
  end

  // add the row sums
  always_comb begin
    for (int c = 0; c < Ch; c++) begin
      sum_nxt[c] = '0;
      for (int kr = 0; kr < Ks; kr++) begin
        sum_nxt[c] = sum_nxt[c] + SumW'(b_rsum_r[c][kr]);
      end
    end
  end

  // reciprocal multiply gives the truncated quotient
  always_comb begin
    for (int c = 0; c < Ch; c++) begin
      prod[c] = ProdW'(c_sum_r[c]) * ProdW'(gblur_pkg::DIV_MUL);
    end
    o_data_nxt.blue_out  = prod[0][Shift +: PixB];
    o_data_nxt.green_out = prod[1][Shift +: PixB];
    o_data_nxt.red_out   = prod[2][Shift +: PixB];
    o_data_nxt.out_row   = c_tag_r.row;
    o_data_nxt.out_col   = c_tag_r.col;
    o_data_nxt.run_last  = c_tag_r.last;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a_win_r  <= win;
      a_tag_r  <= win_tag;
      b_rsum_r <= rsum_nxt;
      b_tag_r  <= a_tag_r;
      c_sum_r  <= sum_nxt;
      c_tag_r  <= b_tag_r;
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

// ----- sv/gaussian_blur_5x5_rgb.sv -----
// 5x5 gaussian blur of a raster bgr pixel stream with edge replication
// An input transfer passes the input stage, the window stage and the sum-and-divide
// registers into the output register. Throughput: one pixel per cycle while out_stall is
// low; the results of a pixel enter the shared sum-and-divide pipeline one after another,
// so a last-column pixel (3 results) or a last-row pixel (3, or 9 at the last column) holds
// the input until its results have entered. Reset (synchronous, active low) clears counters
// and valids and sets 640x480; the line store is not cleared.
module gaussian_blur_5x5_rgb (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gblur_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gblur_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [gblur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gblur_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int MaxW    = gblur_pkg::MAX_WIDTH;
  localparam int Ks      = gblur_pkg::KSIZE;
  localparam int Half    = gblur_pkg::HALF;
  localparam int Lk      = gblur_pkg::LINES_KEPT;
  localparam int ColW    = gblur_pkg::COL_W;
  localparam int EwW     = gblur_pkg::EW_W;
  localparam int SlotW   = gblur_pkg::SLOT_W;
  localparam int IdxW    = gblur_pkg::IDX_W;
  localparam int DxyW    = gblur_pkg::DXY_W;
  localparam int FwW     = gblur_pkg::FW_W;
  localparam int FhW     = gblur_pkg::FH_W;
  localparam int RowW    = gblur_pkg::ROW_W;
  localparam int RowIncW = RowW + 1;
  localparam int OcW     = gblur_pkg::OUT_COL_W;

  // slot of the row k rows above, modulo the bank count
  function automatic logic [SlotW-1:0] slot_back(input logic [SlotW-1:0] s, input int k);
    int t;
    t = int'(s) + Lk - k;
    if (t >= Lk) t = t - Lk;
    return SlotW'(t);
  endfunction

  // configuration and frame position
  logic [FwW-1:0]   frame_width_r;
  logic [FhW-1:0]   frame_height_r;
  logic [EwW-1:0]   eff_w;
  logic [FhW-1:0]   eff_h;
  logic [ColW-1:0]  col_r, cur_col, col_nxt;
  logic [RowW-1:0]  row_r, cur_row, row_nxt;
  logic [SlotW-1:0] slot_r, cur_slot, slot_nxt;
  logic [EwW-1:0]   col_inc;
  logic [RowIncW-1:0] row_inc;

  // handshake and pipeline control
  logic in_fire, adv, s1_free, s2_load, s2_final;
  gblur_pkg::pix_t in_pix;

  // input stage, with the line store read registered alongside it
  logic             s1_valid_r;
  gblur_pkg::pix_t  s1_pix_r;
  logic             s1_first_col_r, s1_emit_r, s1_last_col_r, s1_last_row_r;
  logic [RowW-1:0]  s1_orow_r;
  logic [ColW-1:0]  s1_ocol_r;
  logic [SlotW-1:0] s1_sel_r [Ks-1];
  logic [SlotW-1:0] sel_nxt  [Ks-1];
  gblur_pkg::pix_t [Lk-1:0] rd_data;
  gblur_pkg::pcol_t new_col;

  // window stage: columns [col][row], newest column at the top index
  gblur_pkg::win_t  win_r, win_nxt;
  logic             s2_pend_r;
  logic [DxyW-1:0]  s2_dx_r, s2_dy_r, dx_max, dy_max;
  logic             s2_last_col_r, s2_last_row_r;
  logic [RowW-1:0]  s2_orow_r;
  logic [ColW-1:0]  s2_ocol_r;
  gblur_pkg::win_t  emit_win;
  gblur_pkg::tag_t  emit_tag;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FwW'(gblur_pkg::FRAME_WIDTH_RST);
      frame_height_r <= FhW'(gblur_pkg::FRAME_HEIGHT_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gblur_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FwW-1:0];
        gblur_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FhW-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (int'(frame_width_r) < 3) begin
      eff_w = EwW'(3);
    end else if (int'(frame_width_r) > MaxW) begin
      eff_w = EwW'(MaxW);
    end else begin
      eff_w = EwW'(frame_width_r);
    end
    eff_h = (int'(frame_height_r) < 3) ? FhW'(3) : frame_height_r;
  end

  // current position, restarted if the frame shrank, and the next position
  always_comb begin
    cur_col  = (EwW'(col_r) >= eff_w) ? '0 : col_r;
    if (row_r >= eff_h) begin
      cur_row  = '0;
      cur_slot = '0;
    end else begin
      cur_row  = row_r;
      cur_slot = slot_r;
    end
    col_inc = EwW'(cur_col) + EwW'(1);
    row_inc = RowIncW'(cur_row) + RowIncW'(1);
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      if (row_inc >= RowIncW'(eff_h)) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = RowW'(row_inc);
        slot_nxt = (cur_slot == SlotW'(Lk - 1)) ? '0 : cur_slot + SlotW'(1);
      end
    end else begin
      col_nxt  = ColW'(col_inc);
      row_nxt  = cur_row;
      slot_nxt = cur_slot;
    end
  end

  // banks holding the rows above, clamped to row 0 at the top edge
  always_comb begin
    for (int j = 0; j < Ks - 1; j++) begin
      if (int'(cur_row) >= Ks - 1 - j) begin
        sel_nxt[j] = slot_back(cur_slot, Ks - 1 - j);
      end else begin
        sel_nxt[j] = '0;
      end
    end
  end

  // handshake: everything downstream moves when the result register is free
  assign adv      = !out_valid || !out_stall;
  assign s2_final = s2_pend_r && (s2_dx_r == dx_max) && (s2_dy_r == dy_max);
  assign s2_load  = s1_valid_r && (!s2_pend_r || (s2_final && adv));
  assign s1_free  = !s1_valid_r || s2_load;
  assign in_stall = !s1_free;
  assign in_fire  = in_valid && s1_free;

  assign in_pix[0] = in_data.blue_in;
  assign in_pix[1] = in_data.green_in;
  assign in_pix[2] = in_data.red_in;

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (in_fire) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // line store: write the new pixel, read the rows above at the same column
  gblur_lines u_lines (
    .clk     (clk),
    .en      (in_fire),
    .wr_slot (cur_slot),
    .addr    (cur_col),
    .wr_data (in_pix),
    .rd_data (rd_data)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r       <= in_pix;
      s1_first_col_r <= (cur_col == '0);
      s1_emit_r      <= (cur_row >= RowW'(Half)) && (cur_col >= ColW'(Half));
      s1_last_col_r  <= (EwW'(cur_col) == eff_w - EwW'(1));
      s1_last_row_r  <= (cur_row == eff_h - FhW'(1));
      s1_orow_r      <= cur_row - RowW'(Half);
      s1_ocol_r      <= cur_col - ColW'(Half);
      s1_sel_r       <= sel_nxt;
    end
  end

  // new window column, oldest row at index 0
  always_comb begin
    for (int j = 0; j < Ks - 1; j++) begin
      new_col[j] = rd_data[s1_sel_r[j]];
    end
    new_col[Ks-1] = s1_pix_r;
  end

  // shift the window, or fill it with column 0 at the start of a row
  always_comb begin
    for (int i = 0; i < Ks; i++) begin
      if (s1_first_col_r || (i == Ks - 1)) begin
        win_nxt[i] = new_col;
      end else begin
        win_nxt[i] = win_r[i+1];
      end
    end
  end

  assign dx_max = s2_last_col_r ? DxyW'(Half) : '0;
  assign dy_max = s2_last_row_r ? DxyW'(Half) : '0;

  // window stage: pending results walk columns first, then rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_pend_r <= 1'b0;
    end else if (s2_load) begin
      s2_pend_r <= s1_emit_r;
    end else if (adv && s2_final) begin
      s2_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      win_r         <= win_nxt;
      s2_dx_r       <= '0;
      s2_dy_r       <= '0;
      s2_last_col_r <= s1_last_col_r;
      s2_last_row_r <= s1_last_row_r;
      s2_orow_r     <= s1_orow_r;
      s2_ocol_r     <= s1_ocol_r;
    end else if (adv && s2_pend_r && !s2_final) begin
      if (s2_dx_r == dx_max) begin
        s2_dx_r <= '0;
        s2_dy_r <= s2_dy_r + DxyW'(1);
      end else begin
        s2_dx_r <= s2_dx_r + DxyW'(1);
      end
    end
  end

  // shifted view for this result: replicate the right and bottom edges
  always_comb begin
    logic [IdxW-1:0] ri;
    logic [IdxW-1:0] ci;
    for (int kr = 0; kr < Ks; kr++) begin
      for (int kc = 0; kc < Ks; kc++) begin
        ri = IdxW'(kr) + IdxW'(s2_dy_r);
        ci = IdxW'(kc) + IdxW'(s2_dx_r);
        if (ri > IdxW'(Ks - 1)) ri = IdxW'(Ks - 1);
        if (ci > IdxW'(Ks - 1)) ci = IdxW'(Ks - 1);
        emit_win[kr][kc] = win_r[ci][ri];
      end
    end
    emit_tag.row  = s2_orow_r + RowW'(s2_dy_r);
    emit_tag.col  = OcW'(s2_ocol_r + ColW'(s2_dx_r));
    emit_tag.last = s2_final;
  end

  // sum and divide pipeline ending in the result register
  gblur_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .win_valid (s2_pend_r),
    .win       (emit_win),
    .win_tag   (emit_tag),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // burst position never passes its last result
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_pend_r |-> (s2_dx_r <= dx_max) && (s2_dy_r <= dy_max))
    else $error("burst step beyond its last result");

  // a new window replaces a pending burst only on its final transfer
  a_load_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && s2_pend_r) |-> (adv && s2_final))
    else $error("window replaced while results pending");

  // a stalled burst keeps its place
  a_burst_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_pend_r && !adv) |=> (s2_pend_r && $stable(s2_dx_r) && $stable(s2_dy_r)))
    else $error("burst moved while stalled");

  // store writes stay inside the effective row
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (EwW'(cur_col) < eff_w))
    else $error("column outside frame width");

endmodule

// ----- tb/sv/gblur_check.sv -----
// tracks the blur block's channels, predicts every blurred pixel and compares results
module gblur_check
  import gblur_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KERN_SUM = 273;

  // own copy of the frame geometry, raster position and line rows
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  int              row_pos;
  int              col_pos;
  pix_t            line_mem [LINES_KEPT][MAX_WIDTH];
  out_item_t       blurred_q [$];
  int              mismatches = 0;

  assign fail_count = mismatches;

  // one output pixel from the kept rows, edges replicated
  function automatic out_item_t blur_at(int orow, int ocol, int w, int h);
    out_item_t res;
    int        rr;
    int        cc;
    int        sum_b;
    int        sum_g;
    int        sum_r;
    pix_t      p;
    sum_b = 0;
    sum_g = 0;
    sum_r = 0;
    for (int kr = 0; kr < KSIZE; kr++) begin
      rr = orow + kr - HALF;
      if (rr < 0) rr = 0;
      else if (rr > h - 1) rr = h - 1;
      for (int kc = 0; kc < KSIZE; kc++) begin
        cc = ocol + kc - HALF;
        if (cc < 0) cc = 0;
        else if (cc > w - 1) cc = w - 1;
        p = line_mem[rr % LINES_KEPT][cc];
        sum_b += p[0] * KERN_WT[kr][kc];
        sum_g += p[1] * KERN_WT[kr][kc];
        sum_r += p[2] * KERN_WT[kr][kc];
      end
    end
    res.blue_out  = 8'(sum_b / KERN_SUM);
    res.green_out = 8'(sum_g / KERN_SUM);
    res.red_out   = 8'(sum_r / KERN_SUM);
    res.out_row   = 16'(orow);
    res.out_col   = 11'(ocol);
    res.run_last  = 1'b0;
    return res;
  endfunction

  // store one input pixel and queue the blurred pixels it releases
  task automatic blur_released(in_item_t px);
    int        w;
    int        h;
    int        r;
    int        c;
    int        row_hi;
    int        col_hi;
    out_item_t res;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg < 3) ? 3 : height_reg;
    // a shrunk frame restarts the column or the row
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    line_mem[r % LINES_KEPT][c] = {px.red_in, px.green_in, px.blue_in};
    if (r >= 2 && c >= 2) begin
      row_hi = (r == h - 1) ? r : r - 2;
      col_hi = (c == w - 1) ? c : c - 2;
      for (int orow = r - 2; orow <= row_hi; orow++) begin
        for (int ocol = c - 2; ocol <= col_hi; ocol++) begin
          res = blur_at(orow, ocol, w, h);
          res.run_last = (orow == row_hi) && (ocol == col_hi);
          blurred_q = {blurred_q, res};
        end
      end
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // compare one result transfer with the oldest predicted pixel
  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (blurred_q.size() == 0) begin
      $display("%0t: result %h with nothing expected", $time, got);
      mismatches++;
    end else begin
      want = blurred_q.pop_front();
      check_field("blue_out", want.blue_out, got.blue_out);
      check_field("green_out", want.green_out, got.green_out);
      check_field("red_out", want.red_out, got.red_out);
      check_field("out_row", want.out_row, got.out_row);
      check_field("out_col", want.out_col, got.out_col);
      check_field("run_last", want.run_last, got.run_last);
    end
  endtask

  // sample every transfer and register write at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = FW_W'(FRAME_WIDTH_RST);
      height_reg = FH_W'(FRAME_HEIGHT_RST);
      blurred_q.delete();
    end else begin
      if (out_valid && !out_stall) compare_result(out_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg = cfg_wdata[FW_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_wdata[FH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) blur_released(in_data);
    end
    pending_cnt <= blurred_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// top of the blur testbench: clock, reset, pixel and register stimulus, verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gblur_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PIXELS = 200;
  localparam int WIDE_COLS     = 24;
  localparam int WIDE_SHRUNK_W = 5;
  // indexes past the register list, writes there change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   fail_count;
  int                   pending_cnt;
  int                   cycle_cnt = 0;
  bit                   no_idle = 1'b0;

  // corner frame: channels at their extremes
  in_item_t corner_px [9] = '{24'hFFFFFF, 24'h000000, 24'hFF00FF,
                              24'h00FF00, 24'hFFFFFF, 24'h0000FF,
                              24'hFF0000, 24'h00FFFF, 24'hFFFF00};

  always #CLK_HALF clk = ~clk;

  gaussian_blur_5x5_rgb dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gblur_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // one pixel transfer, valid stays high afterwards
  task automatic send_pixel(in_item_t px);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [31:0] rnd;
    repeat (count) begin
      rnd = $urandom;
      send_pixel(rnd[23:0]);
    end
  endtask

  // drop valid, wait for every predicted pixel, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side stall
  initial begin
    int hold;
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int          w_raw;
    int          h_raw;
    int          w_eff;
    int          h_eff;
    int          w_new;
    int          h_new;
    int          rows_done;
    int          cols_done;
    int          random_done;
    logic [31:0] rnd;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame via out-of-range zero sizes, extreme channel values
    write_reg(CFG_FRAME_WIDTH, 16'h0000);
    write_reg(CFG_FRAME_HEIGHT, 16'h0000);
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    settle();

    // spare indexes, undersized registers with junk upper bits, saturated pixels
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'hFFFF);
    write_reg(CFG_FRAME_WIDTH, 16'hF002);
    write_reg(CFG_FRAME_HEIGHT, 16'h0002);
    repeat (9) send_pixel('1);
    settle();

    // width register saturated to the widest frame, then shrunk within row 0
    write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    send_random(WIDE_COLS);
    settle();
    write_reg(CFG_FRAME_WIDTH, 16'(WIDE_SHRUNK_W));
    send_random(3 * WIDE_SHRUNK_W);
    settle();

    // random frames, some shrunk in the middle
    random_done = 0;
    while (random_done < RANDOM_PIXELS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      rnd = $urandom;
      case ($urandom_range(0, 5))
        0: begin
          // width shrinks past the current column
          w_raw     = $urandom_range(6, 12);
          h_raw     = $urandom_range(3, 6);
          rows_done = $urandom_range(0, h_raw - 1);
          w_new     = $urandom_range(3, w_raw - 1);
          cols_done = $urandom_range(w_new, w_raw - 1);
          write_reg(CFG_FRAME_WIDTH, {rnd[15:12], 12'(w_raw)});
          write_reg(CFG_FRAME_HEIGHT, 16'(h_raw));
          send_random(rows_done * w_raw + cols_done);
          settle();
          write_reg(CFG_FRAME_WIDTH, 16'(w_new));
          send_random((h_raw - rows_done) * w_new);
          settle();
          random_done += rows_done * w_raw + cols_done + (h_raw - rows_done) * w_new;
        end
        1: begin
          // height shrinks below the current row, raster wraps to row 0
          w_raw     = $urandom_range(3, 8);
          h_raw     = rnd[0] ? 65535 : $urandom_range(8, 10);
          rows_done = $urandom_range(4, 7);
          cols_done = $urandom_range(0, w_raw - 1);
          h_new     = $urandom_range(0, rows_done);
          h_eff     = (h_new < 3) ? 3 : h_new;
          write_reg(CFG_FRAME_WIDTH, {rnd[15:12], 12'(w_raw)});
          write_reg(CFG_FRAME_HEIGHT, 16'(h_raw));
          send_random(rows_done * w_raw + cols_done);
          settle();
          write_reg(CFG_FRAME_HEIGHT, 16'(h_new));
          send_random(h_eff * w_raw - cols_done);
          settle();
          random_done += rows_done * w_raw + h_eff * w_raw;
        end
        default: begin
          // whole frame, now and then with undersized registers
          w_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
          h_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
          w_eff = (w_raw < 3) ? 3 : w_raw;
          h_eff = (h_raw < 3) ? 3 : h_raw;
          write_reg(CFG_FRAME_WIDTH, {rnd[15:12], 12'(w_raw)});
          write_reg(CFG_FRAME_HEIGHT, 16'(h_raw));
          send_random(w_eff * h_eff);
          settle();
          random_done += w_eff * h_eff;
        end
      endcase
    end

    // verdict
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gblur_pkg.sv
sv/gblur_lines.sv
sv/gblur_conv.sv
sv/gaussian_blur_5x5_rgb.sv
tb/sv/gblur_check.sv
tb/sv/tb_top.sv
